### hw/rtl/lp2c_pkg.sv
// shared constants and types for the lidar polar to cartesian converter
// arctangent table, fixed-point widths and register indexes; no dependencies
`timescale 1ns / 1ps

package lp2c_pkg;

	localparam int IDX_W   = 11;
	localparam int RANGE_W = 16;
	localparam int ANGLE_W = 16;
	localparam int POINT_W = 17;

	// a sample index at or beyond this gives no point
	localparam int unsigned MAX_SCAN_POINTS = 2048;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES     = 24;

	// vector carried in Q16 millimetres, residual angle with 2^32 per turn
	localparam int XY_W   = 35;
	localparam int Z_W    = 33;
	localparam int GAIN_W = 30;
	localparam int PROD_W = RANGE_W + GAIN_W;

	// cordic gain in Q30
	localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

	localparam logic signed [POINT_W-1:0] OUT_LIMIT = 17'sd65535;

	localparam logic [31:0] ATAN_UNITS [ATAN_ENTRIES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	localparam logic REG_ANGLE_START = 1'b0;
	localparam logic REG_ANGLE_STEP  = 1'b1;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} lp2c_vec_t;

endpackage

### hw/rtl/lidar_polar_to_cartesian.sv
// lidar scan sample to cartesian point converter, pipelined cordic rotation
// depends on lp2c_pkg and lp2c_cordic_stage
//
// channel    | dir | fields (lowest bit up)
// s_axis     | in  | tdata: sample_index[10:0], range_value[26:11]; tuser: range_infinite
// m_axis     | out | tdata: point_x[16:0], point_y[33:17]
// cfg        | in  | cfg_we, cfg_index, cfg_wdata: angle_start, angle_step
//
// one sample accepted per clock unless m_axis stalls; registers, in order:
// (angle multiply, quadrant fold, one register per rotation step, rounding)
// infinite readings and out-of-scan indexes leave the pipeline as bubbles
// reset clears every valid bit and both angle registers at once
// each stage holds its beat while the next is full, so a stall loses nothing
`timescale 1ns / 1ps

module lidar_polar_to_cartesian #(
	parameter int CORDIC_STEPS = lp2c_pkg::CORDIC_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [31:0]                 s_axis_tdata,  // sample_index, range_value
	input  logic                        s_axis_tuser,  // range_infinite
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [39:0]                 m_axis_tdata,  // point_x, point_y
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [lp2c_pkg::ANGLE_W-1:0] cfg_wdata
);
	import lp2c_pkg::*;

	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;

	logic [ANGLE_W-1:0] angle_start_q;
	logic [ANGLE_W-1:0] angle_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_start_q <= '0;
			angle_step_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ANGLE_START: angle_start_q <= cfg_wdata;
				REG_ANGLE_STEP:  angle_step_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage 1: beam angle and scaled range
	logic [IDX_W-1:0]         in_idx;
	logic [RANGE_W-1:0]       in_range;
	logic                     in_keep;
	logic [IDX_W+ANGLE_W-1:0] ang_prod;
	logic                     valid_s1;
	logic                     ready_s1;
	logic [ANGLE_W-1:0]       theta_s1;
	logic [PROD_W-1:0]        prod_s1;
	logic                     ready_s2;

	assign in_idx   = s_axis_tdata[IDX_W-1:0];
	assign in_range = s_axis_tdata[IDX_W+RANGE_W-1:IDX_W];
	assign in_keep  = !s_axis_tuser && (32'(in_idx) < MAX_SCAN_POINTS);
	assign ang_prod = {{ANGLE_W{1'b0}}, in_idx} * {{IDX_W{1'b0}}, angle_step_q};

	assign ready_s1      = !valid_s1 || ready_s2;
	assign s_axis_tready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_axis_tvalid && in_keep;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_axis_tvalid) begin
			theta_s1 <= angle_start_q + ang_prod[ANGLE_W-1:0];
			prod_s1  <= PROD_W'(in_range) * PROD_W'(GAIN_Q30);
		end
	end

	// stage 2: quadrant fold into [-pi/2, pi/2)
	logic [1:0]             quad;
	logic signed [XY_W-1:0] x0;
	logic signed [15:0]     z16;
	lp2c_vec_t              fold;
	logic                   valid_s2;
	lp2c_vec_t              vec_s2;

	logic                   stg_valid [CORDIC_STEPS+1];
	logic                   stg_ready [CORDIC_STEPS+1];
	lp2c_vec_t              stg_vec   [CORDIC_STEPS+1];

	assign quad = theta_s1[ANGLE_W-1:ANGLE_W-2];
	assign x0   = XY_W'(prod_s1[PROD_W-1:14]);

	always_comb begin
		case (quad) inside
			QUAD_1, QUAD_2: begin
				fold.x = -x0;
				z16    = signed'(theta_s1 ^ 16'h8000);
			end
			default: begin
				fold.x = x0;
				z16    = signed'(theta_s1);
			end
		endcase
		fold.y = '0;
		fold.z = {z16[15], z16, 16'b0};
	end

	assign ready_s2 = !valid_s2 || stg_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			vec_s2 <= fold;
		end
	end

	assign stg_valid[0] = valid_s2;
	assign stg_vec[0]   = vec_s2;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		lp2c_cordic_stage #(
			.STEP(k)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (stg_valid[k]),
			.in_ready (stg_ready[k]),
			.in_vec   (stg_vec[k]),
			.out_valid(stg_valid[k+1]),
			.out_ready(stg_ready[k+1]),
			.out_vec  (stg_vec[k+1])
		);
	end

	// last stage: round half up and saturate
	logic signed [XY_W-1:0]    xr;
	logic signed [XY_W-1:0]    yr;
	logic signed [XY_W-17:0]   xw;
	logic signed [XY_W-17:0]   yw;
	logic signed [POINT_W-1:0] x_sat;
	logic signed [POINT_W-1:0] y_sat;
	logic                      ready_out;
	logic                      valid_out_q;
	logic [POINT_W-1:0]        x_out_q;
	logic [POINT_W-1:0]        y_out_q;

	assign xr = stg_vec[CORDIC_STEPS].x + XY_W'(32768);
	assign yr = stg_vec[CORDIC_STEPS].y + XY_W'(32768);
	assign xw = xr[XY_W-1:16];
	assign yw = yr[XY_W-1:16];

	always_comb begin
		if (xw > (XY_W-16)'(OUT_LIMIT)) begin
			x_sat = OUT_LIMIT;
		end else if (xw < -(XY_W-16)'(OUT_LIMIT)) begin
			x_sat = -OUT_LIMIT;
		end else begin
			x_sat = xw[POINT_W-1:0];
		end
		if (yw > (XY_W-16)'(OUT_LIMIT)) begin
			y_sat = OUT_LIMIT;
		end else if (yw < -(XY_W-16)'(OUT_LIMIT)) begin
			y_sat = -OUT_LIMIT;
		end else begin
			y_sat = yw[POINT_W-1:0];
		end
	end

	assign ready_out              = !valid_out_q || m_axis_tready;
	assign stg_ready[CORDIC_STEPS] = ready_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out_q <= 1'b0;
		end else if (ready_out) begin
			valid_out_q <= stg_valid[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && stg_valid[CORDIC_STEPS]) begin
			x_out_q <= x_sat;
			y_out_q <= y_sat;
		end
	end

	assign m_axis_tvalid = valid_out_q;
	assign m_axis_tdata  = {6'b0, y_out_q, x_out_q};

	// dropped samples never reach the pipeline
	a_drop_infinite: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !valid_s1)
		else $error("infinite reading entered the pipeline");

	// fold stage keeps its beat while the first rotation stage is full
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !stg_ready[0] |=> valid_s2 && $stable(vec_s2))
		else $error("fold stage lost a beat under stall");

	// saturation keeps the most negative code off the output
	a_sat_x: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[16:0] != 17'h10000)
		else $error("point_x beyond limit");

	a_sat_y: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[33:17] != 17'h10000)
		else $error("point_y beyond limit");

endmodule

### hw/rtl/lp2c_cordic_stage.sv
// one registered cordic rotation step with its own beat handshake
// depends on lp2c_pkg for the vector type and arctangent table
`timescale 1ns / 1ps

module lp2c_cordic_stage #(
	parameter int STEP = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lp2c_pkg::lp2c_vec_t in_vec,
	output logic              out_valid,
	input  logic              out_ready,
	output lp2c_pkg::lp2c_vec_t out_vec
);
	import lp2c_pkg::*;

	localparam logic signed [Z_W-1:0] ATAN_Z = Z_W'(ATAN_UNITS[STEP]);

	logic signed [XY_W-1:0] x_in;
	logic signed [XY_W-1:0] y_in;
	logic signed [Z_W-1:0]  z_in;
	logic signed [XY_W-1:0] dx;
	logic signed [XY_W-1:0] dy;
	lp2c_vec_t              nxt;
	logic                   valid_q;
	lp2c_vec_t              vec_q;

	assign x_in = in_vec.x;
	assign y_in = in_vec.y;
	assign z_in = in_vec.z;
	// arithmetic shift gives floor for negative values
	assign dx = y_in >>> STEP;
	assign dy = x_in >>> STEP;

	always_comb begin
		if (!z_in[Z_W-1]) begin
			nxt.x = x_in - dx;
			nxt.y = y_in + dy;
			nxt.z = z_in - ATAN_Z;
		end else begin
			nxt.x = x_in + dx;
			nxt.y = y_in - dy;
			nxt.z = z_in + ATAN_Z;
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			vec_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_vec   = vec_q;

endmodule

### tb/sv/tb_lidar_polar_to_cartesian.sv
// self-checking bench for lidar_polar_to_cartesian: directed, random and back-pressure tests
// holds its own cordic predictor; depends on lp2c_pkg and the converter rtl
`timescale 1ns / 1ps

module tb_lidar_polar_to_cartesian;

	import lp2c_pkg::*;

	localparam int          ROT_STEPS   = 16;
	localparam int unsigned SCAN_POINTS = 2048;
	localparam int          DRAIN       = ROT_STEPS + 13;
	localparam int          LONG_HOLD   = 300;
	localparam longint      KGAIN_Q30   = 64'd652032874;
	localparam longint      MM_LIMIT    = 65535;

	// atan(2^-i), 2^32 per turn
	localparam longint ATAN_BAM32 [24] = '{
		536870912, 316933406, 167458907, 85004756,
		42667331,  21354465,  10679838,  5340245,
		2670163,   1335087,   667544,    333772,
		166886,    83443,     41722,     20861,
		10430,     5215,      2608,      1304,
		652,       326,       163,       81
	};

	typedef struct packed {
		logic signed [16:0] x;
		logic signed [16:0] y;
	} point_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [31:0] s_tdata = '0;     // sample_index, range_value
	logic        s_tuser = 1'b0;   // range_infinite
	logic        m_tready = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_ANGLE_START;
	logic [15:0] cfg_wdata = '0;
	logic        s_axis_tready;
	logic        m_axis_tvalid;
	logic [39:0] m_axis_tdata;     // point_x, point_y

	logic [15:0] cur_start = '0;
	logic [15:0] cur_step = '0;
	point_t      expected_points [$];

	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int hold_reqs = 0;
	int faults = 0;
	int samples_sent = 0;
	int samples_dropped = 0;
	int points_checked = 0;
	int angle_settings = 0;

	lidar_polar_to_cartesian #(
		.CORDIC_STEPS(ROT_STEPS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_tdata),
		.s_axis_tuser (s_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 8);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic signed [16:0] round_mm(input longint v);
		longint r;
		r = (v + 32768) >>> 16;
		if (r > MM_LIMIT)
			r = MM_LIMIT;
		if (r < -MM_LIMIT)
			r = -MM_LIMIT;
		return r[16:0];
	endfunction

	function automatic point_t polar_to_point(input logic [10:0] idx, input logic [15:0] rng);
		int unsigned sum;
		logic [15:0] theta;
		longint      x, y, z, dx, dy;
		point_t      p;
		sum = 32'(cur_start) + 32'(idx) * 32'(cur_step);
		theta = sum[15:0];
		x = (longint'(rng) * KGAIN_Q30) >>> 14;
		y = 0;
		// fold the second and third quadrants onto the first and fourth
		if (theta[15:14] == 2'd1 || theta[15:14] == 2'd2) begin
			x = -x;
			z = longint'(theta) - 32768;
		end else if (theta[15:14] == 2'd3) begin
			z = longint'(theta) - 65536;
		end else begin
			z = longint'(theta);
		end
		z = z * 65536;
		for (int i = 0; i < ROT_STEPS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_BAM32[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_BAM32[i];
			end
		end
		p.x = round_mm(x);
		p.y = round_mm(y);
		return p;
	endfunction

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_seen;
		int hold_left;
		int stall_left;
		hold_seen = 0;
		hold_left = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (rx_idle_on)
					stall_left = pick_gap();
			end
		end
	end

	// compare every output beat with the oldest predicted point
	initial begin
		point_t got;
		point_t want;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_tready) begin
				got.x = m_axis_tdata[16:0];
				got.y = m_axis_tdata[33:17];
				if (expected_points.size() == 0) begin
					faults++;
					if (faults <= 10)
						$display("unexpected point x=%0d y=%0d", got.x, got.y);
				end else begin
					want = expected_points.pop_front();
					if (got.x !== want.x || got.y !== want.y) begin
						faults++;
						if (faults <= 10)
							$display("point %0d: expected x=%0d y=%0d, got x=%0d y=%0d",
								points_checked, want.x, want.y, got.x, got.y);
					end
					points_checked++;
				end
			end
		end
	end

	task automatic send_sample(input logic [10:0] idx, input logic [15:0] rng, input logic inf);
		int gap;
		gap = tx_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, rng, idx};
		s_tuser <= inf;
		do @(posedge clk); while (!s_axis_tready);
		samples_sent++;
		if (inf || idx >= SCAN_POINTS)
			samples_dropped++;
		else
			expected_points = {expected_points, polar_to_point(idx, rng)};
	endtask

	// dropped samples leave no trace in the queue, so allow the full latency as well
	task automatic settle_pipeline();
		s_tvalid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_angles(input logic [15:0] start_bam, input logic [15:0] step_bam);
		settle_pipeline();
		cfg_we <= 1'b1;
		cfg_index <= REG_ANGLE_START;
		cfg_wdata <= start_bam;
		@(posedge clk);
		cfg_index <= REG_ANGLE_STEP;
		cfg_wdata <= step_bam;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_start = start_bam;
		cur_step = step_bam;
		angle_settings++;
	endtask

	function automatic logic [15:0] pick_angle();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 16'h0000;
		if (r == 1)
			return 16'hFFFF;
		return 16'($urandom());
	endfunction

	function automatic logic [15:0] pick_range();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return 16'($urandom_range(0, 15));
		if (r < 30)
			return 16'($urandom_range(65520, 65535));
		return 16'($urandom());
	endfunction

	task automatic random_sample();
		send_sample(11'($urandom()), pick_range(), $urandom_range(9) == 0);
	endtask

	task automatic test_directed();
		// reset angles: every beam at zero
		send_sample(11'd0, 16'd0, 1'b0);
		send_sample(11'd2047, 16'hFFFF, 1'b0);
		send_sample(11'd5, 16'd1234, 1'b1);
		send_sample(11'd2047, 16'hFFFF, 1'b1);
		// quarter-turn step: axes, saturation at full range and wrap past a turn
		set_angles(16'd0, 16'd16384);
		for (int i = 0; i < 6; i++)
			send_sample(11'(i), 16'hFFFF, 1'b0);
		// both angle registers at their maximum, sum overflows
		set_angles(16'hFFFF, 16'hFFFF);
		send_sample(11'd2047, 16'hFFFF, 1'b0);
		send_sample(11'd0, 16'hFFFF, 1'b0);
		send_sample(11'd1, 16'd1, 1'b0);
		// just below and exactly on the quadrant boundaries
		set_angles(16'd16383, 16'd16384);
		for (int i = 0; i < 4; i++)
			send_sample(11'(i), 16'hFFFF, 1'b0);
		set_angles(16'd16384, 16'd16384);
		for (int i = 0; i < 4; i++)
			send_sample(11'(i), 16'd40000, 1'b0);
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 5; phase++) begin
			set_angles(pick_angle(), pick_angle());
			repeat (200) random_sample();
		end
	endtask

	task automatic test_backpressure();
		set_angles(pick_angle(), pick_angle());
		tx_idle_on = 1'b0;
		hold_reqs++;
		repeat (120) random_sample();
		tx_idle_on = 1'b1;
	endtask

	task automatic test_no_idle();
		set_angles(pick_angle(), 16'd1);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		repeat (100) random_sample();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		test_no_idle();
		settle_pipeline();
		$display("%0d samples sent, %0d dropped as infinite, %0d points checked",
			samples_sent, samples_dropped, points_checked);
		$display("%0d angle settings, one long output hold-off, random gaps on both sides",
			angle_settings);
		if (faults == 0) begin
			$display("PASS");
		end else begin
			$display("%0d faults", faults);
			$display("FAIL");
		end
		$finish;
	end

endmodule
